// File: hdl/aesv_pkg.sv
// ----------------------------------------------------------------------------
// aesv_pkg: shared types, constants and byte functions
// Payload structs, S-box tables and GF(2^8) helpers for the cipher pipeline.
// ----------------------------------------------------------------------------
package aesv_pkg;

    typedef struct packed {
        logic        opcode;
        logic [63:0] block_in_high;
        logic [63:0] block_in_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] block_out_high;
        logic [63:0] block_out_low;
    } out_item_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam int NUM_ROUNDS = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    localparam logic [7:0] MIX_FWD [4] = '{8'd1, 8'd4, 8'd4, 8'd5};
    localparam logic [7:0] MIX_INV [4] = '{8'd165, 8'd7, 8'd26, 8'd115};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = xtime(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sub_fwd(input logic [7:0] x);
        logic [7:0] idx;
        idx = xtime(x) ^ 8'h01;
        return SBOX[idx];
    endfunction

    function automatic logic [7:0] sub_inv(input logic [7:0] y);
        return gf_mul(INV_SBOX[y] ^ 8'h01, 8'd141);
    endfunction

    // byte i of a 128-bit state, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

endpackage

// File: hdl/aesv_key_stage.sv
// ----------------------------------------------------------------------------
// aesv_key_stage: one step of the key schedule
// Derives the next round key from the previous one with the given constant.
// ----------------------------------------------------------------------------
module aesv_key_stage (
    input  logic [127:0] key_prev,
    input  logic [7:0]   rcon,
    output logic [127:0] key_next
);

    logic [31:0] w [4];
    logic [31:0] t;
    logic [31:0] n [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            w[i] = key_prev[127 - 32 * i -: 32];
        end
        t = {aesv_pkg::SBOX[w[3][23:16]] ^ rcon, aesv_pkg::SBOX[w[3][15:8]],
             aesv_pkg::SBOX[w[3][7:0]], aesv_pkg::SBOX[w[3][31:24]]};
        n[0] = w[0] ^ t;
        n[1] = w[1] ^ n[0];
        n[2] = w[2] ^ n[1];
        n[3] = w[3] ^ n[2];
        key_next = {n[0], n[1], n[2], n[3]};
    end

endmodule

// File: hdl/aesv_round.sv
// ----------------------------------------------------------------------------
// aesv_round: one encryption or decryption round
// Substitution, row shift, column mix and key addition for either direction.
// ----------------------------------------------------------------------------
module aesv_round (
    input  logic         decrypt,
    input  logic         do_mix,
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    output logic [127:0] state_out
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] coef [4];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = aesv_pkg::get_byte(state_in, i);
        end
        for (int i = 0; i < 4; i++)
        begin
            coef[i] = decrypt ? aesv_pkg::MIX_INV[i] : aesv_pkg::MIX_FWD[i];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (decrypt)
                begin
                    t[r + 4 * c] = aesv_pkg::sub_inv(s[r + 4 * ((c - r + 4) % 4)]);
                end
                else
                begin
                    t[r + 4 * c] = aesv_pkg::sub_fwd(s[r + 4 * ((c + r) % 4)]);
                end
            end
        end
        // decryption adds the key before mixing, encryption after
        if (decrypt)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t[i] = t[i] ^ aesv_pkg::get_byte(round_key, i);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m[4 * c + i] = 8'h00;
                for (int j = 0; j < 4; j++)
                begin
                    m[4 * c + i] = m[4 * c + i]
                        ^ aesv_pkg::gf_mul(coef[(j - i + 4) % 4], t[4 * c + j]);
                end
                if (!do_mix)
                begin
                    m[4 * c + i] = t[4 * c + i];
                end
            end
        end
        if (!decrypt)
        begin
            for (int i = 0; i < 16; i++)
            begin
                m[i] = m[i] ^ aesv_pkg::get_byte(round_key, i);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            state_out[127 - 8 * i -: 8] = m[i];
        end
    end

endmodule

// File: hdl/aes128_variant_block_cipher_top.sv
// Pipeline: an input transaction passes through an input stage for the first
// key addition, then ten round stages.
// Throughput: one block per cycle; the whole pipeline holds while out_stall
// blocks a valid result. Round keys are expanded once per key write, one per
// cycle, holding the input off until all are written; likewise after reset.
// Reset clears valid bits and both key registers to zero.
// ----------------------------------------------------------------------------
// aes128_variant_block_cipher_top: pipelined modified AES-128 cipher
// Encrypts or decrypts one block per cycle, unless stalled, under a configured 128-bit key.
// ----------------------------------------------------------------------------
module aes128_variant_block_cipher_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  aesv_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output aesv_pkg::out_item_t  out_item
);

    localparam int NR = aesv_pkg::NUM_ROUNDS;
    localparam logic [3:0] KEY_LAST = 4'd10;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;

    logic [127:0] rk_reg    [NR + 1];
    logic [127:0] kexp_reg;
    logic [127:0] kexp_next;
    logic [3:0]   kcnt_reg;
    logic         key_busy_reg;
    logic [127:0] key_load;
    logic         cfg_write;

    logic         vld_reg   [NR + 1];
    logic         dec_reg   [NR + 1];
    logic [127:0] state_reg [NR + 1];

    logic         advance;
    logic [127:0] stage_key [NR];
    logic [127:0] round_out [NR];

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign key_load   = (cfg_index == aesv_pkg::REG_KEY_HIGH) ? {cfg_data, key_low_reg}
                                                                : {key_high_reg, cfg_data};
    assign advance    = !out_stall || !vld_reg[NR];
    assign in_stall   = !advance || key_busy_reg;
    assign out_valid  = vld_reg[NR];
    assign out_item   = {state_reg[NR][127:64], state_reg[NR][63:0]};

    aesv_key_stage u_key (
        .key_prev (kexp_reg),
        .rcon     (aesv_pkg::RCON[kcnt_reg]),
        .key_next (kexp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
            for (int i = 0; i <= NR; i++)
            begin
                rk_reg[i] <= 128'd0;
            end
            kexp_reg     <= 128'd0;
            kcnt_reg     <= 4'd1;
            key_busy_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aesv_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aesv_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
            rk_reg[0]    <= key_load;
            kexp_reg     <= key_load;
            kcnt_reg     <= 4'd1;
            key_busy_reg <= 1'b1;
        end
        else if (key_busy_reg)
        begin
            rk_reg[kcnt_reg] <= kexp_next;
            kexp_reg         <= kexp_next;
            if (kcnt_reg == KEY_LAST)
            begin
                key_busy_reg <= 1'b0;
            end
            else
            begin
                kcnt_reg <= kcnt_reg + 4'd1;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < NR; k++)
        begin : g_round
            assign stage_key[k] = dec_reg[k] ? rk_reg[NR - 1 - k] : rk_reg[k + 1];

            aesv_round u_round (
                .decrypt   (dec_reg[k]),
                .do_mix    (k != NR - 1),
                .state_in  (state_reg[k]),
                .round_key (stage_key[k]),
                .state_out (round_out[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NR; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid && !key_busy_reg;
            for (int i = 1; i <= NR; i++)
            begin
                vld_reg[i] <= vld_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dec_reg[0]   <= (in_item.opcode == aesv_pkg::OP_DECRYPT);
            state_reg[0] <= {in_item.block_in_high, in_item.block_in_low}
                            ^ ((in_item.opcode == aesv_pkg::OP_DECRYPT) ? rk_reg[NR]
                                                                         : rk_reg[0]);
            for (int i = 1; i <= NR; i++)
            begin
                dec_reg[i]   <= dec_reg[i - 1];
                state_reg[i] <= round_out[i - 1];
            end
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the modified AES-128 block cipher
// Drives encrypt and decrypt transactions under several keys, predicts each
// result block in the bench and compares it with the pipeline output in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES = 400000;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [0:0]          cfg_index;
    logic [63:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    aesv_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    aesv_pkg::out_item_t out_item;

    aes128_variant_block_cipher_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    aesv_pkg::in_item_t  pending_blocks[$];
    aesv_pkg::out_item_t expected_blocks[$];
    logic [63:0] model_key_high;
    logic [63:0] model_key_low;
    int  mismatches;
    int  cycle_count;
    int  blocks_sent;
    int  blocks_checked;
    int  enc_count;
    int  dec_count;
    int  keys_used;
    int  sent_mark;
    bit  quiet;
    bit  hold_req;
    bit  hold_done;
    int  src_gap;
    int  sink_gap;
    int  hold_off;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbox_inverse(input logic [7:0] y);
        for (int i = 0; i < 256; i++)
            if (aesv_pkg::SBOX[i] == y)
                return i[7:0];
        return 8'h00;
    endfunction

    function automatic aesv_pkg::out_item_t cipher_block(input aesv_pkg::in_item_t it,
                                                         input logic [63:0] kh,
                                                         input logic [63:0] kl);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] w [4];
        logic [7:0] f;
        logic [7:0] a [4];
        logic [7:0] v;
        logic [7:0] coef [4];
        aesv_pkg::out_item_t res;
        for (int i = 0; i < 8; i++)
        begin
            rk[i]     = kh[63 - 8 * i -: 8];
            rk[8 + i] = kl[63 - 8 * i -: 8];
            st[i]     = it.block_in_high[63 - 8 * i -: 8];
            st[8 + i] = it.block_in_low[63 - 8 * i -: 8];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = rk[i - 4 + j];
            if ((i % 16) == 0)
            begin
                f = w[0];
                w[0] = aesv_pkg::SBOX[w[1]] ^ aesv_pkg::RCON[i / 16];
                w[1] = aesv_pkg::SBOX[w[2]];
                w[2] = aesv_pkg::SBOX[w[3]];
                w[3] = aesv_pkg::SBOX[f];
            end
            for (int j = 0; j < 4; j++)
                rk[i + j] = rk[i - 16 + j] ^ w[j];
        end
        if (it.opcode == aesv_pkg::OP_ENCRYPT)
        begin
            coef = '{8'd1, 8'd4, 8'd4, 8'd5};
            for (int i = 0; i < 16; i++)
                st[i] ^= rk[i];
            for (int r = 1; r <= 10; r++)
            begin
                for (int i = 0; i < 16; i++)
                    st[i] = aesv_pkg::SBOX[gmul(st[i], 8'd2) ^ 8'h01];
                for (int row = 0; row < 4; row++)
                    for (int c = 0; c < 4; c++)
                        tmp[row + 4 * c] = st[row + 4 * ((c + row) % 4)];
                st = tmp;
                if (r != 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int j = 0; j < 4; j++)
                            a[j] = st[4 * c + j];
                        for (int i = 0; i < 4; i++)
                        begin
                            v = 8'h00;
                            for (int j = 0; j < 4; j++)
                                v ^= gmul(coef[(j - i + 4) % 4], a[j]);
                            st[4 * c + i] = v;
                        end
                    end
                for (int i = 0; i < 16; i++)
                    st[i] ^= rk[16 * r + i];
            end
        end
        else
        begin
            coef = '{8'd165, 8'd7, 8'd26, 8'd115};
            for (int i = 0; i < 16; i++)
                st[i] ^= rk[160 + i];
            for (int r = 9; r >= 0; r--)
            begin
                for (int row = 0; row < 4; row++)
                    for (int c = 0; c < 4; c++)
                        tmp[row + 4 * c] = st[row + 4 * ((c - row + 4) % 4)];
                st = tmp;
                for (int i = 0; i < 16; i++)
                    st[i] = gmul(sbox_inverse(st[i]) ^ 8'h01, 8'd141);
                for (int i = 0; i < 16; i++)
                    st[i] ^= rk[16 * r + i];
                if (r != 0)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int j = 0; j < 4; j++)
                            a[j] = st[4 * c + j];
                        for (int i = 0; i < 4; i++)
                        begin
                            v = 8'h00;
                            for (int j = 0; j < 4; j++)
                                v ^= gmul(coef[(j - i + 4) % 4], a[j]);
                            st[4 * c + i] = v;
                        end
                    end
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            res.block_out_high[63 - 8 * i -: 8] = st[i];
            res.block_out_low[63 - 8 * i -: 8]  = st[8 + i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pattern64();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            default: return rand64();
        endcase
    endfunction

    task automatic queue_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        aesv_pkg::in_item_t it;
        it.opcode = op;
        it.block_in_high = hi;
        it.block_in_low = lo;
        pending_blocks.push_back(it);
    endtask

    task automatic write_key_reg(input logic [0:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == aesv_pkg::REG_KEY_HIGH)
            model_key_high = val;
        else
            model_key_low = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        do
            @(posedge clk);
        while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_key(input logic [63:0] kh, input logic [63:0] kl);
        drain_pipeline();
        write_key_reg(aesv_pkg::REG_KEY_HIGH, kh);
        write_key_reg(aesv_pkg::REG_KEY_LOW, kl);
        keys_used++;
    endtask

    task automatic queue_random_phase(input int count);
        logic [63:0] hi;
        logic [63:0] lo;
        for (int n = 0; n < count; n++)
        begin
            hi = pattern64();
            lo = pattern64();
            queue_block(1'($urandom_range(0, 1)), hi, lo);
        end
    endtask

    // driver: present the next pending transaction after random gaps, hold while stalled
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid && !in_stall)
                blocks_sent++;
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                src_gap <= $urandom_range(0, 3);
                in_valid <= 1'b0;
            end
            else if (pending_blocks.size() > 0)
            begin
                aesv_pkg::in_item_t it;
                it = pending_blocks.pop_front();
                in_item <= it;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // predict on accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_blocks.push_back(cipher_block(in_item, model_key_high, model_key_low));
            if (in_item.opcode == aesv_pkg::OP_ENCRYPT)
                enc_count++;
            else
                dec_count++;
        end
    end

    // long hold-off: count down once requested
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_off <= 60;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
        end
    end

    // sink stall: random bursts, long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
        end
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            sink_gap <= $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h", out_item.block_out_high,
                             out_item.block_out_low);
            end
            else
            begin
                aesv_pkg::out_item_t exp_blk;
                exp_blk = expected_blocks.pop_front();
                blocks_checked++;
                if (out_item.block_out_high !== exp_blk.block_out_high ||
                    out_item.block_out_low !== exp_blk.block_out_low)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("block %0d: expected %h %h got %h %h", blocks_checked,
                                 exp_blk.block_out_high, exp_blk.block_out_low,
                                 out_item.block_out_high, out_item.block_out_low);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = aesv_pkg::REG_KEY_HIGH;
        cfg_data = 64'h0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        model_key_high = 64'h0;
        model_key_low = 64'h0;
        mismatches = 0;
        cycle_count = 0;
        blocks_sent = 0;
        blocks_checked = 0;
        enc_count = 0;
        dec_count = 0;
        keys_used = 0;
        sent_mark = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key of all zeros, directed block extremes
        queue_block(aesv_pkg::OP_ENCRYPT, 64'h0, 64'h0);
        queue_block(aesv_pkg::OP_DECRYPT, 64'h0, 64'h0);
        queue_block(aesv_pkg::OP_ENCRYPT, '1, '1);
        queue_block(aesv_pkg::OP_DECRYPT, '1, '1);
        load_key('1, '1);
        queue_block(aesv_pkg::OP_ENCRYPT, 64'h0, 64'h0);
        queue_block(aesv_pkg::OP_DECRYPT, '1, '1);
        queue_block(aesv_pkg::OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block(aesv_pkg::OP_DECRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        load_key(64'h000102030405060a, 64'h08090a0b0c0d0e0f);
        queue_block(aesv_pkg::OP_ENCRYPT, 64'h8000000000000000, 64'h0);
        queue_block(aesv_pkg::OP_DECRYPT, 64'h0, 64'h1);
        queue_block(aesv_pkg::OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        queue_block(aesv_pkg::OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        load_key(64'h0, '1);
        queue_block(aesv_pkg::OP_ENCRYPT, '1, 64'h0);
        queue_block(aesv_pkg::OP_DECRYPT, 64'h0, '1);

        // long sink hold-off so the pipeline fills and stalls the source
        load_key(rand64(), rand64());
        sent_mark = blocks_sent;
        queue_random_phase(60);
        wait (blocks_sent > sent_mark + 5);
        hold_req = 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            load_key(pattern64(), pattern64());
            queue_random_phase(110);
        end
        drain_pipeline();
        quiet = 1'b1;
        load_key(rand64(), rand64());
        queue_random_phase(40);
        drain_pipeline();

        $display("%0d blocks checked (%0d encrypt, %0d decrypt) under %0d key settings",
                 blocks_checked, enc_count, dec_count, keys_used);
        $display("covered key reloads, a long output hold-off and a gap-free final burst");
        if (mismatches == 0)
            $display("tb OK");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
